>>> hw/rtl/cts_pkg.sv
package cts_pkg;

    localparam int SLOTS       = 8;
    localparam int MAX_OUT     = 8;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SNUM_W      = ($clog2(SLOTS + 1) > 4) ? $clog2(SLOTS + 1) : 4;
    localparam int OCNT_W      = $clog2(MAX_OUT + 1);
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [1:0] {
        REQ_ADD      = 2'd0,
        REQ_DEL      = 2'd1,
        REQ_TICK     = 2'd2,
        REQ_DISPATCH = 2'd3
    } req_kind_t;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [SNUM_W-1:0] snum_t;
    typedef logic [OCNT_W-1:0] ocnt_t;

    typedef struct packed {
        logic [7:0]  task_code;
        logic [15:0] countdown;
        logic [15:0] interval;
        logic [7:0]  pending_runs;
    } slot_rec_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [7:0]  task_code;
        logic [15:0] first_delay;
        logic [15:0] repeat_period;
        logic [5:0]  slot_index;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot_number;
        logic [7:0] run_code;
        logic       run_valid;
    } res_t;

    function automatic res_t make_res(logic [1:0] status, snum_t num, logic [7:0] code,
                                      logic valid);
        res_t r;
        r.status      = status;
        r.slot_number = num[3:0];
        r.run_code    = code;
        r.run_valid   = valid;
        return r;
    endfunction

endpackage

>>> hw/rtl/cts_cell.sv
// One slot of the ring: takes its neighbour's record whenever the ring turns.
module cts_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  cts_pkg::slot_rec_t   rec_in,
    output cts_pkg::slot_rec_t   rec_out
);

    cts_pkg::slot_rec_t rec_reg;
    cts_pkg::slot_rec_t rec_next;

    always_comb
    begin
        rec_next = rec_reg;
        if (shift)
        begin
            rec_next = rec_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec_out = rec_reg;

endmodule

>>> hw/rtl/cts_slot_alu.sv
// Update of the slot record at the head of the ring for the current request.
module cts_slot_alu
(
    input  cts_pkg::req_t       req,
    input  cts_pkg::slot_rec_t  rec,
    input  cts_pkg::idx_t       pos,
    input  logic                found,
    input  logic                room,
    output cts_pkg::slot_rec_t  rec_new,
    output logic                hit,
    output cts_pkg::res_t       res
);

    logic occupied;

    always_comb
    begin
        occupied = (rec.task_code != 8'd0);
        rec_new  = rec;
        hit      = 1'b0;
        res      = cts_pkg::make_res(cts_pkg::STAT_OK, cts_pkg::snum_t'(pos), 8'd0, 1'b0);

        case (req.kind)
            cts_pkg::REQ_ADD:
            begin
                // only the lowest free slot takes the task
                if (!occupied && !found)
                begin
                    hit                  = 1'b1;
                    rec_new.task_code    = req.task_code;
                    rec_new.countdown    = req.first_delay;
                    rec_new.interval     = req.repeat_period;
                    rec_new.pending_runs = 8'd0;
                end
            end
            cts_pkg::REQ_DEL:
            begin
                if (req.slot_index == 6'(pos))
                begin
                    hit     = 1'b1;
                    rec_new = '0;
                end
            end
            cts_pkg::REQ_TICK:
            begin
                if (occupied)
                begin
                    if (rec.countdown == 16'd0)
                    begin
                        rec_new.pending_runs = rec.pending_runs + 8'd1;
                        if (rec.interval != 16'd0)
                        begin
                            rec_new.countdown = rec.interval - 16'd1;
                        end
                    end
                    else
                    begin
                        rec_new.countdown = rec.countdown - 16'd1;
                    end
                end
            end
            cts_pkg::REQ_DISPATCH:
            begin
                if (occupied && rec.pending_runs != 8'd0 && room)
                begin
                    hit = 1'b1;
                    res = cts_pkg::make_res(cts_pkg::STAT_OK, cts_pkg::snum_t'(pos),
                                            rec.task_code, 1'b1);
                    rec_new.pending_runs = rec.pending_runs - 8'd1;
                    // one-shot task leaves the table once run
                    if (rec.interval == 16'd0)
                    begin
                        rec_new = '0;
                    end
                end
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

endmodule

>>> hw/rtl/cooperative_task_scheduler_table.sv
// Cooperative task scheduler table. The slot records sit in a ring of cells
// that turns by one slot per cycle unless held while an output word waits
// for m_tready; the slot at the head is updated by a single update unit and
// written back at the tail, so every request (add, delete, tick, dispatch)
// takes one full turn of the ring: it is accepted, all SLOTS slots are then
// scanned, and then its final result is issued. Dispatch words come out in
// slot order, and the last word of each request carries m_tlast. A tick
// produces no word, nor does a dispatch with nothing pending. New requests
// are taken while the previous final word still sits in the output register.
module cooperative_task_scheduler_table
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // task_code[7:0], first_delay[23:8], repeat_period[39:24], slot_index[45:40]
    input  logic [cts_pkg::IN_TDATA_W-1:0]        s_tdata,
    // req_type[1:0]
    input  logic [1:0]                            s_tuser,

    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // status[1:0], slot_number[5:2], run_code[13:6], zero pad
    output logic [cts_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // run_valid[0]
    output logic                                  m_tuser,
    output logic                                  m_tlast
);

    cts_pkg::state_t    state_reg, state_next;
    cts_pkg::req_t      req_reg, req_next;
    cts_pkg::idx_t      pos_reg, pos_next;
    cts_pkg::ocnt_t     count_reg, count_next;
    logic               hold_valid_reg, hold_valid_next;
    cts_pkg::res_t      hold_reg, hold_next;
    logic               out_valid_reg, out_valid_next;
    cts_pkg::res_t      out_reg, out_next;
    logic               out_last_reg, out_last_next;

    cts_pkg::slot_rec_t ring [cts_pkg::SLOTS];
    cts_pkg::slot_rec_t alu_rec;
    cts_pkg::res_t      alu_res;
    cts_pkg::res_t      final_res;
    logic               alu_hit;
    logic               shift;
    logic               out_free;
    logic               stall;
    logic               room;
    logic               final_valid;

    genvar k;
    generate
        for (k = 0; k < cts_pkg::SLOTS; k++)
        begin : g_cell
            if (k == cts_pkg::SLOTS - 1)
            begin : g_tail
                cts_cell u_cell
                (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .shift   (shift),
                    .rec_in  (alu_rec),
                    .rec_out (ring[k])
                );
            end
            else
            begin : g_mid
                cts_cell u_cell
                (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .shift   (shift),
                    .rec_in  (ring[k + 1]),
                    .rec_out (ring[k])
                );
            end
        end
    endgenerate

    assign room = (count_reg < cts_pkg::ocnt_t'(cts_pkg::MAX_OUT));

    cts_slot_alu u_alu
    (
        .req     (req_reg),
        .rec     (ring[0]),
        .pos     (pos_reg),
        .found   (hold_valid_reg),
        .room    (room),
        .rec_new (alu_rec),
        .hit     (alu_hit),
        .res     (alu_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        shift           = 1'b0;
        out_free        = !out_valid_reg || m_tready;
        stall           = 1'b0;
        final_valid     = 1'b0;
        final_res       = hold_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (req_reg.kind)
            cts_pkg::REQ_ADD:
            begin
                final_valid = 1'b1;
                if (!hold_valid_reg)
                begin
                    final_res = cts_pkg::make_res(cts_pkg::STAT_FULL,
                                                  cts_pkg::snum_t'(cts_pkg::SLOTS),
                                                  8'd0, 1'b0);
                end
            end
            cts_pkg::REQ_DEL:
            begin
                final_valid = 1'b1;
                if (!hold_valid_reg)
                begin
                    final_res = cts_pkg::make_res(cts_pkg::STAT_RANGE, '0, 8'd0, 1'b0);
                end
            end
            default:
            begin
                final_valid = hold_valid_reg;
            end
        endcase

        case (state_reg)
            cts_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next.kind          = cts_pkg::req_kind_t'(s_tuser);
                    req_next.task_code     = s_tdata[7:0];
                    req_next.first_delay   = s_tdata[23:8];
                    req_next.repeat_period = s_tdata[39:24];
                    req_next.slot_index    = s_tdata[45:40];
                    pos_next               = '0;
                    count_next             = '0;
                    hold_valid_next        = 1'b0;
                    state_next             = cts_pkg::ST_SCAN;
                end
            end
            cts_pkg::ST_SCAN:
            begin
                // a second dispatch word needs the held one moved out first
                stall = alu_hit && hold_valid_reg && !out_free;
                if (!stall)
                begin
                    shift    = 1'b1;
                    pos_next = pos_reg + cts_pkg::idx_t'(1);
                    if (alu_hit)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = hold_reg;
                            out_last_next  = 1'b0;
                        end
                        hold_next       = alu_res;
                        hold_valid_next = 1'b1;
                        if (req_reg.kind == cts_pkg::REQ_DISPATCH)
                        begin
                            count_next = count_reg + cts_pkg::ocnt_t'(1);
                        end
                    end
                    if (pos_reg == cts_pkg::idx_t'(cts_pkg::SLOTS - 1))
                    begin
                        state_next = cts_pkg::ST_DONE;
                    end
                end
            end
            cts_pkg::ST_DONE:
            begin
                if (!final_valid)
                begin
                    state_next = cts_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = final_res;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = cts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cts_pkg::ST_IDLE;
            pos_reg        <= '0;
            count_reg      <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            count_reg      <= count_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == cts_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.run_code, out_reg.slot_number, out_reg.status, 1'b0} >> 1;
    assign m_tuser  = out_reg.run_valid;
    assign m_tlast  = out_last_reg;

    // nothing is held between requests
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cts_pkg::ST_IDLE |-> !hold_valid_reg)
        else $error("held result left over in idle");

    // the final word goes out as soon as the output register is free
    a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cts_pkg::ST_DONE && out_free) |=> state_reg == cts_pkg::ST_IDLE)
        else $error("final word not issued");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cts_pkg::ocnt_t'(cts_pkg::MAX_OUT))
        else $error("dispatch count beyond limit");

    // an add never has to wait on the output during its scan
    a_add_nostall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cts_pkg::ST_SCAN && req_reg.kind == cts_pkg::REQ_ADD) |-> !stall)
        else $error("add scan stalled");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RAND_PER_PHASE = 55;
    localparam int HOLD_AT_ITEM   = 30;
    localparam int WRAP_TICKS     = 257;

    localparam int PACE_SRC_LIGHT = 0;  // sender 32 %, receiver 75 %
    localparam int PACE_SRC_HEAVY = 1;  // sender 75 %, receiver 32 %
    localparam int PACE_NONE      = 2;

    // status, slot_number, run_code, run_valid, last
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
        logic [7:0] code;
        logic       valid;
        logic       last;
    } sched_word_t;

    typedef struct {
        cts_pkg::req_t r;
        bit            typed;
        sched_word_t   want;
    } dir_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [cts_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic [1:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [cts_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;

    // scoreboard copy of the slot table
    logic [7:0]  task_of       [cts_pkg::SLOTS];
    logic [15:0] delay_left    [cts_pkg::SLOTS];
    logic [15:0] reload_period [cts_pkg::SLOTS];
    logic [7:0]  runs_owed     [cts_pkg::SLOTS];

    sched_word_t expected_words[$];
    dir_row_t    directed_rows[$];

    int idle_mode = PACE_SRC_LIGHT;
    int stalls_asked = 0;
    int mismatches = 0;
    int words_checked = 0;
    int dispatch_words = 0;
    int full_replies = 0;
    int range_replies = 0;
    int kind_count[4] = '{0, 0, 0, 0};

    cooperative_task_scheduler_table DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one accepted request to the table copy and queue the words it gives.
    // Directed rows with a typed answer queue that instead.
    function automatic void step_table(input cts_pkg::req_t r, input bit typed,
                                       input sched_word_t want);
        sched_word_t burst[$];
        sched_word_t w;
        int free_slot;
        free_slot = -1;
        w = '0;
        kind_count[r.kind]++;
        case (r.kind)
            cts_pkg::REQ_ADD:
            begin
                for (int i = cts_pkg::SLOTS - 1; i >= 0; i--)
                    if (task_of[i] == 8'd0)
                        free_slot = i;
                if (free_slot < 0)
                begin
                    w.status = cts_pkg::STAT_FULL;
                    w.slot   = 4'(cts_pkg::SLOTS);
                    full_replies++;
                end
                else
                begin
                    task_of[free_slot]       = r.task_code;
                    delay_left[free_slot]    = r.first_delay;
                    reload_period[free_slot] = r.repeat_period;
                    runs_owed[free_slot]     = 8'd0;
                    w.status = cts_pkg::STAT_OK;
                    w.slot   = 4'(free_slot);
                end
                burst.push_back(w);
            end
            cts_pkg::REQ_DEL:
            begin
                if (r.slot_index >= cts_pkg::SLOTS)
                begin
                    w.status = cts_pkg::STAT_RANGE;
                    range_replies++;
                end
                else
                begin
                    task_of[r.slot_index]       = 8'd0;
                    delay_left[r.slot_index]    = 16'd0;
                    reload_period[r.slot_index] = 16'd0;
                    runs_owed[r.slot_index]     = 8'd0;
                    w.status = cts_pkg::STAT_OK;
                    w.slot   = 4'(r.slot_index);
                end
                burst.push_back(w);
            end
            cts_pkg::REQ_TICK:
            begin
                for (int i = 0; i < cts_pkg::SLOTS; i++)
                begin
                    if (task_of[i] != 8'd0)
                    begin
                        if (delay_left[i] == 16'd0)
                        begin
                            runs_owed[i] = runs_owed[i] + 8'd1;
                            if (reload_period[i] != 16'd0)
                                delay_left[i] = reload_period[i] - 16'd1;
                        end
                        else
                            delay_left[i] = delay_left[i] - 16'd1;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < cts_pkg::SLOTS && burst.size() < cts_pkg::MAX_OUT; i++)
                begin
                    if (task_of[i] != 8'd0 && runs_owed[i] != 8'd0)
                    begin
                        w.status = cts_pkg::STAT_OK;
                        w.slot   = 4'(i);
                        w.code   = task_of[i];
                        w.valid  = 1'b1;
                        burst.push_back(w);
                        runs_owed[i] = runs_owed[i] - 8'd1;
                        // one-shot task leaves the table once run
                        if (reload_period[i] == 16'd0)
                        begin
                            task_of[i]    = 8'd0;
                            delay_left[i] = 16'd0;
                            runs_owed[i]  = 8'd0;
                        end
                    end
                end
            end
        endcase
        if (burst.size() > 0)
        begin
            w = burst.pop_back();
            w.last = 1'b1;
            burst.push_back(w);
        end
        if (typed)
            expected_words.push_back(want);
        else
            foreach (burst[k])
                expected_words.push_back(burst[k]);
    endfunction

    function automatic dir_row_t mk_row(cts_pkg::req_kind_t k, logic [7:0] c,
                                        logic [15:0] d, logic [15:0] p, logic [5:0] ix,
                                        bit typed, logic [1:0] st, logic [3:0] sn);
        dir_row_t row;
        row.r.kind          = k;
        row.r.task_code     = c;
        row.r.first_delay   = d;
        row.r.repeat_period = p;
        row.r.slot_index    = ix;
        row.typed           = typed;
        row.want            = '{status: st, slot: sn, code: 8'd0, valid: 1'b0, last: 1'b1};
        return row;
    endfunction

    // Mostly small delays and periods so tasks fire often; now and then full-range values.
    function automatic cts_pkg::req_t pick_request();
        cts_pkg::req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            r.kind = cts_pkg::REQ_ADD;
        else if (pick < 48)
            r.kind = cts_pkg::REQ_DEL;
        else if (pick < 85)
            r.kind = cts_pkg::REQ_TICK;
        else
            r.kind = cts_pkg::REQ_DISPATCH;
        r.task_code = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 15) == 0)
            r.task_code = 8'd0;
        if ($urandom_range(0, 7) == 0)
            r.first_delay = 16'($urandom);
        else
            r.first_delay = 16'($urandom_range(0, 4));
        if ($urandom_range(0, 7) == 0)
            r.repeat_period = 16'($urandom);
        else
            r.repeat_period = 16'($urandom_range(0, 5));
        if ($urandom_range(0, 5) == 0)
            r.slot_index = 6'($urandom);
        else
            r.slot_index = 6'($urandom_range(0, cts_pkg::SLOTS - 1));
        return r;
    endfunction

    task automatic offer_request(input cts_pkg::req_t r, input bit typed,
                                 input sched_word_t want);
        int gap_pct;
        gap_pct = (idle_mode == PACE_SRC_LIGHT) ? 32 : (idle_mode == PACE_SRC_HEAVY) ? 75 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {2'b00, r.slot_index, r.repeat_period, r.first_delay, r.task_code};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        step_table(r, typed, want);
    endtask

    function automatic void report(string what, sched_word_t want, sched_word_t seen);
        mismatches++;
        if (mismatches <= 10)
        begin
            $write("%0t %s: expected st=%0d slot=%0d code=%0h run=%0b last=%0b, ",
                   $time, what, want.status, want.slot, want.code, want.valid, want.last);
            $display("got st=%0d slot=%0d code=%0h run=%0b last=%0b",
                     seen.status, seen.slot, seen.code, seen.valid, seen.last);
        end
    endfunction

    // result side: check accepted words, drive m_tready
    initial
    begin
        sched_word_t seen;
        sched_word_t want;
        int hold_left;
        int stalls_done;
        int busy_pct;
        hold_left   = 0;
        stalls_done = 0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                seen = '{status: m_tdata[1:0], slot: m_tdata[5:2], code: m_tdata[13:6],
                         valid: m_tuser, last: m_tlast};
                words_checked++;
                if (seen.valid)
                    dispatch_words++;
                if (expected_words.size() == 0)
                    report("word with nothing expected", '0, seen);
                else
                begin
                    want = expected_words.pop_front();
                    if (seen !== want)
                        report("word mismatch", want, seen);
                end
            end
            if (stalls_asked != stalls_done)
            begin
                stalls_done = stalls_asked;
                hold_left   = HOLD_CYCLES;
            end
            busy_pct = (idle_mode == PACE_SRC_LIGHT) ? 75 : (idle_mode == PACE_SRC_HEAVY) ? 32 : 0;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= busy_pct);
        end
    end

    // watchdog: cycles with no word moving on either side
    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog expired with %0d words outstanding", expected_words.size());
        $display("cooperative_task_scheduler_table test failed");
        $finish;
    end

    initial
    begin
        cts_pkg::req_t r;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        for (int i = 0; i < cts_pkg::SLOTS; i++)
        begin
            task_of[i]       = 8'd0;
            delay_left[i]    = 16'd0;
            reload_period[i] = 16'd0;
            runs_owed[i]     = 8'd0;
        end

        directed_rows = '{
            mk_row(cts_pkg::REQ_DISPATCH, 8'h00, 16'h0000, 16'h0000, 6'd0,
                   0, cts_pkg::STAT_OK, 4'd0),
            mk_row(cts_pkg::REQ_DEL, 8'hFF, 16'hFFFF, 16'hFFFF, 6'd63,
                   1, cts_pkg::STAT_RANGE, 4'd0),
            mk_row(cts_pkg::REQ_DEL, 8'h00, 16'h0000, 16'h0000, 6'd8,
                   1, cts_pkg::STAT_RANGE, 4'd0),
            mk_row(cts_pkg::REQ_DEL, 8'h00, 16'h0000, 16'h0000, 6'd7,
                   1, cts_pkg::STAT_OK, 4'd7),
            // code 0 takes the slot but leaves it free
            mk_row(cts_pkg::REQ_ADD, 8'h00, 16'hFFFF, 16'hFFFF, 6'd0,
                   1, cts_pkg::STAT_OK, 4'd0),
            mk_row(cts_pkg::REQ_ADD, 8'hFF, 16'h0000, 16'h0000, 6'd63,
                   1, cts_pkg::STAT_OK, 4'd0),
            mk_row(cts_pkg::REQ_ADD, 8'h01, 16'hFFFF, 16'hFFFF, 6'd0,
                   1, cts_pkg::STAT_OK, 4'd1),
            mk_row(cts_pkg::REQ_ADD, 8'h5A, 16'h0000, 16'h0001, 6'd0,
                   1, cts_pkg::STAT_OK, 4'd2),
            mk_row(cts_pkg::REQ_ADD, 8'hA5, 16'h0001, 16'h0003, 6'd0,
                   1, cts_pkg::STAT_OK, 4'd3),
            // one-shot at zero gains a run on both ticks
            mk_row(cts_pkg::REQ_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 6'd63,
                   0, cts_pkg::STAT_OK, 4'd0),
            mk_row(cts_pkg::REQ_TICK, 8'h00, 16'h0000, 16'h0000, 6'd0,
                   0, cts_pkg::STAT_OK, 4'd0),
            mk_row(cts_pkg::REQ_DISPATCH, 8'hFF, 16'hFFFF, 16'hFFFF, 6'd63,
                   0, cts_pkg::STAT_OK, 4'd0),
            mk_row(cts_pkg::REQ_DISPATCH, 8'h00, 16'h0000, 16'h0000, 6'd0,
                   0, cts_pkg::STAT_OK, 4'd0),
            mk_row(cts_pkg::REQ_ADD, 8'h11, 16'h0000, 16'h0002, 6'd0,
                   0, cts_pkg::STAT_OK, 4'd0),
            mk_row(cts_pkg::REQ_ADD, 8'h22, 16'h0000, 16'h0000, 6'd0,
                   0, cts_pkg::STAT_OK, 4'd0),
            mk_row(cts_pkg::REQ_ADD, 8'h33, 16'h0000, 16'h0001, 6'd0,
                   0, cts_pkg::STAT_OK, 4'd0),
            mk_row(cts_pkg::REQ_ADD, 8'h44, 16'h0000, 16'h0005, 6'd0,
                   0, cts_pkg::STAT_OK, 4'd0),
            mk_row(cts_pkg::REQ_ADD, 8'h80, 16'h0000, 16'h8000, 6'd0,
                   0, cts_pkg::STAT_OK, 4'd0),
            mk_row(cts_pkg::REQ_ADD, 8'h99, 16'h0000, 16'h0001, 6'd0,
                   1, cts_pkg::STAT_FULL, 4'(cts_pkg::SLOTS)),
            mk_row(cts_pkg::REQ_TICK, 8'h00, 16'h0000, 16'h0000, 6'd0,
                   0, cts_pkg::STAT_OK, 4'd0),
            mk_row(cts_pkg::REQ_TICK, 8'h00, 16'h0000, 16'h0000, 6'd0,
                   0, cts_pkg::STAT_OK, 4'd0),
            mk_row(cts_pkg::REQ_TICK, 8'h00, 16'h0000, 16'h0000, 6'd0,
                   0, cts_pkg::STAT_OK, 4'd0),
            mk_row(cts_pkg::REQ_DISPATCH, 8'h00, 16'h0000, 16'h0000, 6'd0,
                   0, cts_pkg::STAT_OK, 4'd0),
            mk_row(cts_pkg::REQ_DEL, 8'h00, 16'h0000, 16'h0000, 6'd2,
                   1, cts_pkg::STAT_OK, 4'd2),
            mk_row(cts_pkg::REQ_DISPATCH, 8'h00, 16'h0000, 16'h0000, 6'd0,
                   0, cts_pkg::STAT_OK, 4'd0)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_request(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].want);

        for (int phase = PACE_SRC_LIGHT; phase <= PACE_NONE; phase++)
        begin
            idle_mode = phase;
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                // long result-side hold while requests keep coming
                if (phase == PACE_SRC_LIGHT && n == HOLD_AT_ITEM)
                    stalls_asked++;
                offer_request(pick_request(), 0, '0);
            end
        end

        // run counter wrap: one task owed 257 runs reads back as one
        r = '{kind: cts_pkg::REQ_DEL, task_code: 8'h00, first_delay: 16'h0,
              repeat_period: 16'h0, slot_index: 6'd0};
        for (int i = 0; i < cts_pkg::SLOTS; i++)
        begin
            r.slot_index = 6'(i);
            offer_request(r, 0, '0);
        end
        r = '{kind: cts_pkg::REQ_ADD, task_code: 8'h77, first_delay: 16'h0,
              repeat_period: 16'h1, slot_index: 6'd0};
        offer_request(r, 0, '0);
        r.kind = cts_pkg::REQ_TICK;
        for (int i = 0; i < WRAP_TICKS; i++)
            offer_request(r, 0, '0);
        r.kind = cts_pkg::REQ_DISPATCH;
        offer_request(r, 0, '0);
        offer_request(r, 0, '0);
        s_tvalid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Requests: %0d add, %0d delete, %0d tick, %0d dispatch;",
                 kind_count[cts_pkg::REQ_ADD], kind_count[cts_pkg::REQ_DEL],
                 kind_count[cts_pkg::REQ_TICK], kind_count[cts_pkg::REQ_DISPATCH]);
        $display("%0d full, %0d out of range; result words checked: %0d (%0d dispatches), mismatches: %0d.",
                 full_replies, range_replies, words_checked, dispatch_words, mismatches);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("cooperative_task_scheduler_table test passed");
        else
            $display("cooperative_task_scheduler_table test failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/cts_pkg.sv
hw/rtl/cts_cell.sv
hw/rtl/cts_slot_alu.sv
hw/rtl/cooperative_task_scheduler_table.sv
verif/testbench.sv
